FILE: rtl/core/mfrag_pkg.sv
// Shared types and constants for the message fragmenter.
// Used by mfrag_in_stage, mfrag_seq and message_fragmenter; no dependencies.
`default_nettype none

package mfrag_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 16;
  localparam int CNT_W = 8;
  localparam int HDR_BYTES = 3;
  localparam int IN_W = BYTE_W + LEN_W;
  localparam int USER_W = 2;

  typedef struct packed {
    logic [LEN_W-1:0]  message_length;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              packet_end;
    logic              is_payload;
    logic              message_end;
  } beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/mfrag_in_stage.sv
// Input register for the message fragmenter: holds one accepted input beat
// until the sequencer consumes its payload byte. Depends on mfrag_pkg.
`default_nettype none

module mfrag_in_stage
  import mfrag_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  input  logic  take,
  output logic  valid,
  output item_t item
);

  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mfrag_seq.sv
// Header/payload sequencer: message and packet state, packet count, and the
// selection of the next output beat. Depends on mfrag_pkg.
`default_nettype none

module mfrag_seq
  import mfrag_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 247
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid,
  input  item_t item,
  input  logic  ld,
  output logic  take,
  output beat_t beat
);

  localparam int PAY_EFF = (PAYLOAD_BYTES < 1) ? 1 : PAYLOAD_BYTES;
  localparam logic [CNT_W:0] PAY_CMP = (CNT_W + 1)'(PAY_EFF);
  localparam int NUM_W = LEN_W + 1;
  localparam int SHIFT = NUM_W + CNT_W;
  localparam int RECIP_W = SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(PAY_EFF) - 64'd1) / 64'(PAY_EFF));

  typedef enum logic [1:0] {PH_ID, PH_INDEX, PH_COUNT, PH_DATA} phase_t;

  phase_t              phase;
  phase_t              phase_next;
  logic [BYTE_W-1:0]   message_id;
  logic [LEN_W-1:0]    bytes_sent;
  logic [CNT_W-1:0]    offset;
  logic [CNT_W-1:0]    packet_index;
  logic [CNT_W-1:0]    packet_count;

  logic [LEN_W-1:0]         len_eff;
  logic                     start;
  logic [BYTE_W-1:0]        id_eff;
  logic [NUM_W-1:0]         numer;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [CNT_W-1:0]         count_calc;
  logic                     hdr;
  logic [LEN_W:0]           sent_inc;
  logic                     mend;
  logic                     pend;

  always_comb begin
    len_eff = (item.message_length == '0) ? LEN_W'(1) : item.message_length;
    start = (bytes_sent == '0);
    id_eff = start ? (message_id + BYTE_W'(1)) : message_id;
    numer = {1'b0, len_eff} + NUM_W'(PAY_EFF - 1);
    prod = (NUM_W + RECIP_W)'(numer) * (NUM_W + RECIP_W)'(RECIP);
    count_calc = prod[SHIFT +: CNT_W];
    hdr = (offset == '0) && (phase != PH_DATA);
    sent_inc = {1'b0, bytes_sent} + (LEN_W + 1)'(1);
    mend = (sent_inc >= {1'b0, len_eff});
    pend = mend || (({1'b0, offset} + (CNT_W + 1)'(1)) >= PAY_CMP);
    take = ld && valid && !hdr;

    beat = '0;
    if (hdr) begin
      case (phase)
        PH_ID:    beat.out_byte = id_eff;
        PH_INDEX: beat.out_byte = packet_index;
        PH_COUNT: beat.out_byte = packet_count;
        default:  beat.out_byte = item.data_byte;
      endcase
    end else begin
      beat.out_byte = item.data_byte;
      beat.packet_end = pend;
      beat.is_payload = 1'b1;
      beat.message_end = mend;
    end

    case (phase)
      PH_ID:    phase_next = PH_INDEX;
      PH_INDEX: phase_next = PH_COUNT;
      PH_COUNT: phase_next = PH_DATA;
      default:  phase_next = PH_ID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ID;
      message_id <= '0;
      bytes_sent <= '0;
      offset <= '0;
      packet_index <= '0;
      packet_count <= '0;
    end else if (ld && valid) begin
      if (hdr) begin
        phase <= phase_next;
        if (phase == PH_ID && start) begin
          message_id <= id_eff;
          packet_count <= count_calc;
        end
      end else begin
        phase <= PH_ID;
        if (mend) begin
          bytes_sent <= '0;
          offset <= '0;
          packet_index <= '0;
        end else begin
          bytes_sent <= sent_inc[LEN_W-1:0];
          if (pend) begin
            offset <= '0;
            packet_index <= packet_index + CNT_W'(1);
          end else begin
            offset <= offset + CNT_W'(1);
          end
        end
      end
    end
  end

  a_hdr_in_progress: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_ID) |-> (offset == '0 && valid))
    else $error("header in progress outside a packet start");

  a_msg_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && beat.message_end) |=>
      (bytes_sent == '0 && offset == '0 && packet_index == '0))
    else $error("message end did not clear position state");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, offset} < PAY_CMP))
    else $error("offset beyond payload size");

  a_hdr_advance: assert property (@(posedge clk) disable iff (rst)
    (ld && valid && hdr) |=> (phase != PH_ID))
    else $error("header beat did not advance phase");

endmodule

`default_nettype wire

FILE: rtl/core/message_fragmenter.sv
// A beat accepted on the slave side passes the input register, then the output register,
// before its first result shows on the master side.
// Inside a packet, one input beat per cycle while the master side does not stall;
// a beat opening a packet waits while three header bytes precede its payload byte.
// Reset (rst, synchronous): empties both registers, message id and all counters go to zero.
// Top level: input register, sequencer and output register. Depends on mfrag_pkg.
`default_nettype none

module message_fragmenter
  import mfrag_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 247
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // data_byte[7:0], message_length[23:8]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // out_byte[7:0]
  output logic              m_axis_tlast,
  output logic [USER_W-1:0] m_axis_tuser    // is_payload[0], message_end[1]
);

  item_t s_item;
  item_t item;
  logic  valid;
  logic  take;
  logic  ld;
  beat_t beat;
  beat_t out_beat;

  assign s_item.data_byte = s_axis_tdata[BYTE_W-1:0];
  assign s_item.message_length = s_axis_tdata[IN_W-1:BYTE_W];

  mfrag_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .take    (take),
    .valid   (valid),
    .item    (item)
  );

  mfrag_seq #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .valid (valid),
    .item  (item),
    .ld    (ld),
    .take  (take),
    .beat  (beat)
  );

  assign ld = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ld) begin
      m_axis_tvalid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_beat <= beat;
    end
  end

  assign m_axis_tdata = out_beat.out_byte;
  assign m_axis_tlast = out_beat.packet_end;
  assign m_axis_tuser = {out_beat.message_end, out_beat.is_payload};

endmodule

`default_nettype wire
